>>> rtl/pps_pkg.sv
// pps_pkg: shared types and codes for the preemptive priority scheduler
// depends on nothing; used by every rtl file of the block
`timescale 1ns / 1ps

package pps_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_TERMINATE = 3'd1,
    EV_SUSPEND   = 3'd2,
    EV_START     = 3'd3,
    EV_RESUME    = 3'd4,
    EV_ALL_DONE  = 3'd5
  } event_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  process_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_ticks;
    logic [7:0]  priority_level;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  event_process;
    logic [15:0] time_now;
    logic        table_full;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  process_id;
    logic [15:0] arrival_time;
    logic [15:0] remaining;
    logic [7:0]  priority_level;
  } entry_t;

  typedef struct packed {
    logic push;
    out_t word;
  } push_t;

endpackage

>>> rtl/pps_table.sv
// pps_table: process table memory, one write port and one registered read port
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_table #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  pps_pkg::entry_t    wr_data_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output pps_pkg::entry_t    rd_data_o
);

  pps_pkg::entry_t mem [Depth];
  pps_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

>>> rtl/pps_ctrl.sv
// pps_ctrl: scheduling sequencer with per-slot flags and two key comparators
// depends on pps_pkg; drives pps_table and the output register of the top level
`timescale 1ns / 1ps

module pps_ctrl #(
  parameter int MaxProc = 16,
  parameter int SlotW   = 4,
  parameter int CntW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pps_pkg::in_t        in_word_i,
  output logic                in_stall_o,
  input  logic                out_free_i,
  output pps_pkg::push_t      push_o,
  input  pps_pkg::entry_t     rd_data_i,
  output logic [SlotW-1:0]    rd_addr_o,
  output logic                wr_en_o,
  output logic [SlotW-1:0]    wr_addr_o,
  output pps_pkg::entry_t     wr_data_o
);

  localparam int KeyW = 24 + SlotW;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DEC     = 8'b0000_0010,
    S_SCAN_RD = 8'b0000_0100,
    S_SCAN_EV = 8'b0000_1000,
    S_PICK    = 8'b0001_0000,
    S_CMP     = 8'b0010_0000,
    S_DISP    = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] pid;
    logic       full;
  } pend_t;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d, fin_q, fin_d, idx_q, idx_d;
  logic [15:0]        tick_q, tick_d;
  logic               run_v_q, run_v_d, best_v_q, best_v_d, term_q, term_d;
  logic               pend_v_q, pend_v_d;
  logic [MaxProc-1:0] adm_q, adm_d, start_q, start_d, rdy_q, rdy_d;
  logic [SlotW-1:0]   run_q, run_d, best_q, best_d;
  logic [KeyW-1:0]    best_key_q, best_key_d;
  logic [7:0]         best_id_q, best_id_d;
  pend_t              pend_q, pend_d;

  logic               can_emit, accept, adm_now, rdy_now;
  logic [SlotW-1:0]   idx_slot;
  logic [KeyW-1:0]    cur_key, run_key;
  logic [15:0]        rem_dec;
  logic               push_last;

  assign idx_slot   = idx_q[SlotW-1:0];
  assign cur_key    = {rd_data_i.priority_level, rd_data_i.arrival_time, idx_slot};
  assign run_key    = {rd_data_i.priority_level, rd_data_i.arrival_time, run_q};
  assign rem_dec    = rd_data_i.remaining - 16'd1;
  assign can_emit   = !pend_v_q || out_free_i;
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign rd_addr_o  = (state_q == S_SCAN_RD) ? idx_slot : run_q;
  assign adm_now    = !adm_q[idx_slot] && (rd_data_i.arrival_time <= tick_q);
  assign rdy_now    = rdy_q[idx_slot] || adm_now;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    fin_d      = fin_q;
    idx_d      = idx_q;
    tick_d     = tick_q;
    run_v_d    = run_v_q;
    run_d      = run_q;
    best_v_d   = best_v_q;
    best_d     = best_q;
    best_key_d = best_key_q;
    best_id_d  = best_id_q;
    term_d     = term_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    adm_d      = adm_q;
    start_d    = start_q;
    rdy_d      = rdy_q;
    push_last  = 1'b0;
    push_o     = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = run_q;
    wr_data_o  = rd_data_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          term_d = 1'b0;
          if (in_word_i.cmd == pps_pkg::CMD_LOAD) begin
            pend_v_d = 1'b1;
            pend_d   = '{ev: pps_pkg::EV_NONE, pid: in_word_i.process_id, full: 1'b0};
            if (cnt_q >= CntW'(MaxProc)) begin
              pend_d.full = 1'b1;
            end else begin
              wr_en_o   = 1'b1;
              wr_addr_o = cnt_q[SlotW-1:0];
              wr_data_o = '{process_id: in_word_i.process_id,
                            arrival_time: in_word_i.arrival_time,
                            remaining: (in_word_i.burst_ticks == 16'd0) ? 16'd1
                                                                       : in_word_i.burst_ticks,
                            priority_level: in_word_i.priority_level};
              adm_d[cnt_q[SlotW-1:0]]   = 1'b0;
              start_d[cnt_q[SlotW-1:0]] = 1'b0;
              rdy_d[cnt_q[SlotW-1:0]]   = 1'b0;
              cnt_d = cnt_q + CntW'(1);
            end
            state_d = S_FIN;
          end else begin
            tick_d   = tick_q + 16'd1;
            best_v_d = 1'b0;
            idx_d    = '0;
            state_d  = run_v_q ? S_DEC : S_SCAN_RD;
          end
        end
      end
      S_DEC: begin
        wr_data_o.remaining = rem_dec;
        if (rem_dec != 16'd0) begin
          wr_en_o = 1'b1;
          state_d = S_SCAN_RD;
        end else if (can_emit) begin
          wr_en_o  = 1'b1;
          push_o.push = pend_v_q;
          pend_v_d = 1'b1;
          pend_d   = '{ev: pps_pkg::EV_TERMINATE, pid: rd_data_i.process_id, full: 1'b0};
          run_v_d  = 1'b0;
          fin_d    = fin_q + CntW'(1);
          term_d   = 1'b1;
          state_d  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = (idx_q >= cnt_q) ? S_PICK : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (adm_now) begin
          adm_d[idx_slot] = 1'b1;
          rdy_d[idx_slot] = 1'b1;
        end
        if (rdy_now && (!best_v_q || (cur_key < best_key_q))) begin
          best_v_d   = 1'b1;
          best_d     = idx_slot;
          best_key_d = cur_key;
          best_id_d  = rd_data_i.process_id;
        end
        idx_d   = idx_q + CntW'(1);
        state_d = S_SCAN_RD;
      end
      S_PICK: begin
        priority if (!best_v_q) begin
          state_d = S_FIN;
        end else if (!run_v_q) begin
          state_d = S_DISP;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (best_key_q < run_key) begin
          if (can_emit) begin
            push_o.push = pend_v_q;
            pend_v_d    = 1'b1;
            pend_d = '{ev: pps_pkg::EV_SUSPEND, pid: rd_data_i.process_id, full: 1'b0};
            rdy_d[run_q] = 1'b1;
            run_v_d      = 1'b0;
            state_d      = S_DISP;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_DISP: begin
        if (can_emit) begin
          push_o.push = pend_v_q;
          pend_v_d    = 1'b1;
          pend_d = '{ev: start_q[best_q] ? pps_pkg::EV_RESUME : pps_pkg::EV_START,
                     pid: best_id_q, full: 1'b0};
          start_d[best_q] = 1'b1;
          rdy_d[best_q]   = 1'b0;
          run_v_d = 1'b1;
          run_d   = best_q;
          term_d  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        priority if (term_q && (fin_q == cnt_q)) begin
          if (can_emit) begin
            push_o.push = pend_v_q;
            pend_v_d    = 1'b1;
            pend_d = '{ev: pps_pkg::EV_ALL_DONE, pid: 8'd0, full: 1'b0};
            term_d = 1'b0;
          end
        end else if (!pend_v_q) begin
          pend_v_d = 1'b1;
          pend_d   = '{ev: pps_pkg::EV_NONE, pid: 8'd0, full: 1'b0};
        end else if (out_free_i) begin
          push_o.push = 1'b1;
          push_last   = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    push_o.word = '{event_res: pend_q.ev, event_process: pend_q.pid, time_now: tick_q,
                    table_full: pend_q.full, last: push_last};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      fin_q    <= '0;
      idx_q    <= '0;
      tick_q   <= '0;
      run_v_q  <= 1'b0;
      best_v_q <= 1'b0;
      term_q   <= 1'b0;
      pend_v_q <= 1'b0;
      adm_q    <= '0;
      start_q  <= '0;
      rdy_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      idx_q    <= idx_d;
      tick_q   <= tick_d;
      run_v_q  <= run_v_d;
      best_v_q <= best_v_d;
      term_q   <= term_d;
      pend_v_q <= pend_v_d;
      adm_q    <= adm_d;
      start_q  <= start_d;
      rdy_q    <= rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q      <= run_d;
    best_q     <= best_d;
    best_key_q <= best_key_d;
    best_id_q  <= best_id_d;
    pend_q     <= pend_d;
  end

`ifndef SYNTHESIS
  a_run_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_v_q |-> (CntW'(run_q) < cnt_q))
    else $error("running slot beyond loaded entries");

  a_fin_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= cnt_q)
    else $error("more finished processes than loaded");

  a_run_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_v_q |-> !rdy_q[run_q])
    else $error("running process also marked ready");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("pending word left when idle");
`endif

endmodule

>>> rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. A load word appends one process entry if the table has
// room and returns one ack word; the input stalls until the ack word is pushed out. A tick
// word walks the process table through the single read port of the table memory, reading
// each entry in S_SCAN_RD and checking it in S_SCAN_EV, admitting arrivals and tracking the
// best ready process with a key comparator; a tick holds off the input until its result words
// are pushed out, also while the output side stalls, and gives one or two result words, the
// final one marked last. The block takes no new word while a tick or load is in progress.
// No clearing pass is needed after reset.
// depends on pps_pkg, pps_table, pps_ctrl
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pps_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pps_pkg::out_t out_word_o
);

  localparam int SlotW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CntW  = $clog2(MAX_PROCESSES + 1);

  pps_pkg::push_t  push;
  pps_pkg::entry_t rd_data, wr_data;
  logic [SlotW-1:0] rd_addr, wr_addr;
  logic             wr_en, out_free;
  logic             out_valid_q, out_valid_d;
  pps_pkg::out_t    out_word_q;

  pps_table #(
    .Depth(MAX_PROCESSES),
    .AddrW(SlotW)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  pps_ctrl #(
    .MaxProc(MAX_PROCESSES),
    .SlotW  (SlotW),
    .CntW   (CntW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_word_i (in_word_i),
    .in_stall_o(in_stall_o),
    .out_free_i(out_free),
    .push_o    (push),
    .rd_data_i (rd_data),
    .rd_addr_o (rd_addr),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.push) begin
      out_word_q <= push.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
